### hdl/lfu_pkg.sv
package lfu_pkg;

  // Geometry of the entry store.
  localparam int CAPACITY   = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W      = $clog2(CAPACITY + 1);

  // Fixed field widths.
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int TOUCH_W = 48;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  // Command codes.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // One entry as held in the memory.
  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [DATA_W-1:0]     data;
    logic [COUNT_BITS-1:0] count;
    logic [TOUCH_W-1:0]    touch;
  } entry_t;

  // Outcome of one pass over the store.
  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [DATA_W-1:0]     hit_data;
    logic [COUNT_BITS-1:0] hit_count;
    logic [IDX_W-1:0]      vic_idx;
    logic [IDX_W-1:0]      free_idx;
  } scan_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } lfu_state_t;

endpackage

### hdl/lfu_if.sv
// Request channel: command, key and value.
interface lfu_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

// Response channel: hit flag and value read.
interface lfu_rsp_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

### hdl/lfu_ram.sv
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/lfu_scan.sv
module lfu_scan (
  input  logic                     clk,
  input  logic                     clear,
  input  logic                     sample,
  input  logic [lfu_pkg::IDX_W-1:0] idx,
  input  lfu_pkg::entry_t          ent,
  input  logic                     ent_valid,
  input  logic [lfu_pkg::KEY_W-1:0] key,
  output lfu_pkg::scan_res_t       res
);
  import lfu_pkg::*;

  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [DATA_W-1:0]     hit_data_r, hit_data_nxt;
  logic [COUNT_BITS-1:0] hit_count_r, hit_count_nxt;
  logic                  vic_found_r, vic_found_nxt;
  logic [IDX_W-1:0]      vic_idx_r, vic_idx_nxt;
  logic [COUNT_BITS-1:0] vic_count_r, vic_count_nxt;
  logic [TOUCH_W-1:0]    vic_touch_r, vic_touch_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic                  better;

  // The first matching key wins; the victim is the lowest count, then the oldest
  // stamp, with the lowest slot kept on a full tie; the first empty slot is kept.
  always_comb begin
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_data_nxt   = hit_data_r;
    hit_count_nxt  = hit_count_r;
    vic_found_nxt  = vic_found_r;
    vic_idx_nxt    = vic_idx_r;
    vic_count_nxt  = vic_count_r;
    vic_touch_nxt  = vic_touch_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    better = !vic_found_r || (ent.count < vic_count_r) ||
             ((ent.count == vic_count_r) && (ent.touch < vic_touch_r));
    if (clear) begin
      hit_nxt        = 1'b0;
      vic_found_nxt  = 1'b0;
      free_found_nxt = 1'b0;
    end else if (sample) begin
      if (ent_valid) begin
        if (!hit_r && (ent.key == key)) begin
          hit_nxt       = 1'b1;
          hit_idx_nxt   = idx;
          hit_data_nxt  = ent.data;
          hit_count_nxt = ent.count;
        end
        if (better) begin
          vic_found_nxt = 1'b1;
          vic_idx_nxt   = idx;
          vic_count_nxt = ent.count;
          vic_touch_nxt = ent.touch;
        end
      end else if (!free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_data_r   <= hit_data_nxt;
    hit_count_r  <= hit_count_nxt;
    vic_found_r  <= vic_found_nxt;
    vic_idx_r    <= vic_idx_nxt;
    vic_count_r  <= vic_count_nxt;
    vic_touch_r  <= vic_touch_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
  end

  assign res = '{hit:       hit_r,
                 hit_idx:   hit_idx_r,
                 hit_data:  hit_data_r,
                 hit_count: hit_count_r,
                 vic_idx:   vic_idx_r,
                 free_idx:  free_idx_r};

endmodule

### hdl/lfu_cache_with_lru_tiebreak.sv
// A get's result is registered in ST_FINISH, after ST_SCAN reads every entry once
// through the single read port of the memory and ST_DRAIN follows. A new beat is taken
// only in ST_IDLE, so each beat is finished before the next is taken in.
// A put gives no result. The output register lets the next beat in while a result waits.
// Reset (synchronous, active low) clears valid bits, occupancy, touch clock and
// sets the capacity limit to 16; entry contents are left as they are.
module lfu_cache_with_lru_tiebreak (
  input  logic                      clk,
  input  logic                      rst_n,
  lfu_req_if.sink                   in_ch,
  lfu_rsp_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CFG_W-1:0] cfg_wdata
);
  import lfu_pkg::*;

  lfu_state_t state_r, state_nxt;

  logic [CFG_W-1:0]    cap_r;
  logic [CAPACITY-1:0] valid_r;
  logic [OCC_W-1:0]    occ_r;
  logic [TOUCH_W-1:0]  clock_r;

  logic              cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] val_r;

  logic [IDX_W-1:0] rd_addr_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;

  logic              out_valid_r;
  logic              out_found_r;
  logic [DATA_W-1:0] out_data_r;

  logic       accept, rd_last, ram_re, finish_go;
  entry_t     rd_ent;
  scan_res_t  scan;

  logic                  wr_en, set_valid, occ_inc, evict, is_get;
  logic [IDX_W-1:0]      wr_slot;
  entry_t                wr_ent;
  logic [COUNT_BITS-1:0] inc_count;

  assign accept  = in_ch.valid && in_ch.ready;
  assign rd_last = (rd_addr_r == IDX_W'(CAPACITY - 1));
  assign is_get  = (cmd_r == CMD_GET);

  // Entry store.
  lfu_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en && finish_go),
    .waddr(wr_slot),
    .wdata(wr_ent),
    .re   (ram_re),
    .raddr(rd_addr_r),
    .rdata(rd_ent)
  );

  // Tracks hit, victim and free slot as entries stream out of the memory.
  lfu_scan u_scan (
    .clk      (clk),
    .clear    (accept),
    .sample   (rd_vld_r),
    .idx      (rd_idx_r),
    .ent      (rd_ent),
    .ent_valid(valid_r[rd_idx_r]),
    .key      (key_r),
    .res      (scan)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_SCAN;
      ST_SCAN:   if (rd_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: if (finish_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    ram_re      = 1'b0;
    finish_go   = 1'b0;
    case (state_r)
      ST_IDLE:   in_ch.ready = 1'b1;
      ST_SCAN:   ram_re = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: finish_go = !is_get || !out_valid_r || out_ch.ready;
      default:   ;
    endcase
  end

  // Write-back decision from the scan results.
  assign inc_count = (scan.hit_count == '1) ? scan.hit_count
                                            : scan.hit_count + COUNT_BITS'(1);
  assign evict = (32'(occ_r) >= 32'(cap_r)) || (32'(occ_r) >= CAPACITY);

  always_comb begin
    wr_en     = 1'b0;
    set_valid = 1'b0;
    occ_inc   = 1'b0;
    wr_slot   = scan.hit_idx;
    wr_ent    = '{key: key_r, data: scan.hit_data, count: inc_count, touch: clock_r};
    if (is_get) begin
      wr_en = scan.hit;
    end else if (cap_r != '0) begin
      wr_en = 1'b1;
      if (scan.hit) begin
        wr_ent.data = val_r;
      end else begin
        wr_slot   = evict ? scan.vic_idx : scan.free_idx;
        wr_ent    = '{key: key_r, data: val_r, count: COUNT_BITS'(1), touch: clock_r};
        set_valid = 1'b1;
        occ_inc   = !evict;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      valid_r     <= '0;
      occ_r       <= '0;
      clock_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= ram_re;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (finish_go && wr_en) begin
        clock_r <= clock_r + TOUCH_W'(1);
      end
      if (finish_go && set_valid) begin
        valid_r[wr_slot] <= 1'b1;
      end
      if (finish_go && occ_inc) begin
        occ_r <= occ_r + OCC_W'(1);
      end
      if (finish_go && is_get) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.command;
      key_r <= in_ch.key;
      val_r <= in_ch.value;
    end
    if (accept) begin
      rd_addr_r <= '0;
    end else if (ram_re && !rd_last) begin
      rd_addr_r <= rd_addr_r + IDX_W'(1);
    end
    rd_idx_r <= rd_addr_r;
    if (finish_go && is_get) begin
      out_found_r <= scan.hit;
      out_data_r  <= scan.hit ? scan.hit_data : MISS_VALUE;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.read_value = out_data_r;

  // The fill count must always agree with the valid bits.
  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(occ_r))
    else $error("occupancy disagrees with valid bits");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= CAPACITY)
    else $error("occupancy above capacity");

  // A result only appears after a finished get.
  a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH) && ($past(cmd_r) == CMD_GET))
    else $error("result raised outside a finished get");

  // The memory is never written while a scan reads it.
  a_no_wr_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> !(wr_en && finish_go))
    else $error("write during scan");

endmodule
